@@ rtl/bracket_match_finder_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bracket match finder
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BRACKET_MATCH_FINDER_CORE_DEFINES_SVH
`define BRACKET_MATCH_FINDER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BMF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BMF_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BMF_ASSERT(label, clk, rst_n, prop, msg)
`define BMF_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

@@ rtl/bmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder package
// Character codes, bracket kinds, queue operation codes, status codes, types.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int MATCH_W  = 20;
    localparam int KIND_W   = 2;
    localparam int OPC_W    = 2;

    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [KIND_W-1:0] KIND_PAREN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [OPC_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPC_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPC_W-1:0] OP_LAST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_CLOSER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STRAY      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_OPEN  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRONG_KIND = 3'd6;
    localparam logic [STATUS_W-1:0] ERR_NONE      = 3'd0;

    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = 2;
    localparam int OPQ_CNT_W = 3;

    typedef struct packed {
        logic [OPC_W-1:0]  code;
        logic [KIND_W-1:0] kind;
    } t_op_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [KIND_W-1:0] opener_kind(input logic [BYTE_W-1:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CH_LPAREN: k = KIND_PAREN;
            CH_LBRACK: k = KIND_BRACK;
            CH_LBRACE: k = KIND_BRACE;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] closer_kind(input logic [BYTE_W-1:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CH_RPAREN: k = KIND_PAREN;
            CH_RBRACK: k = KIND_BRACK;
            CH_RBRACE: k = KIND_BRACE;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/bmf_stream_if.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder channels
// Valid/ready channels for text bytes in and match results out.
// ----------------------------------------------------------------------------
interface bmf_in_if;
    logic                       valid;
    logic                       ready;
    logic [bmf_pkg::BYTE_W-1:0] text_byte;
    logic                       is_closer_byte;

    modport source (output valid, output text_byte, output is_closer_byte, input ready);
    modport sink   (input valid, input text_byte, input is_closer_byte, output ready);
endinterface

interface bmf_out_if;
    logic                         valid;
    logic                         ready;
    logic [bmf_pkg::STATUS_W-1:0] status;
    logic [bmf_pkg::MATCH_W-1:0]  match_position;

    modport source (output valid, output status, output match_position, input ready);
    modport sink   (input valid, input status, input match_position, output ready);
endinterface

@@ rtl/bmf_front.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder front end
// Tracks comments, strings and escapes, numbers bytes, and queues stack ops.
// ----------------------------------------------------------------------------
module bmf_front #(
    parameter int POSITION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bmf_in_if.sink                   i_in_ch,
    input  bmf_pkg::t_q_status       i_q_stat,
    output logic                     o_q_push,
    output bmf_pkg::t_op_ctrl        o_q_ctrl,
    output logic [POSITION_BITS-1:0] o_q_pos
);

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_skip, n_skip;
    logic                     r_comment, n_comment;
    logic                     r_string, n_string;
    logic                     accept;
    logic [bmf_pkg::BYTE_W-1:0] b;
    logic [bmf_pkg::KIND_W-1:0] open_k;
    logic [bmf_pkg::KIND_W-1:0] close_k;

    assign i_in_ch.ready = !i_q_stat.full;
    assign accept        = i_in_ch.valid && i_in_ch.ready;
    assign b             = i_in_ch.text_byte;
    assign open_k        = bmf_pkg::opener_kind(b);
    assign close_k       = bmf_pkg::closer_kind(b);
    assign o_q_pos       = r_pos;

    always_comb begin
        n_pos          = r_pos;
        n_skip         = r_skip;
        n_comment      = r_comment;
        n_string       = r_string;
        o_q_push       = 1'b0;
        o_q_ctrl.code  = bmf_pkg::OP_PUSH;
        o_q_ctrl.kind  = open_k;
        if (accept) begin
            n_pos = r_pos + 1'b1;
            if (i_in_ch.is_closer_byte) begin
                // The last item ends the scan and restarts numbering.
                o_q_push      = 1'b1;
                o_q_ctrl.code = bmf_pkg::OP_LAST;
                o_q_ctrl.kind = close_k;
                n_pos         = '0;
                n_skip        = 1'b0;
                n_comment     = 1'b0;
                n_string      = 1'b0;
            end else if (r_skip) begin
                n_skip = 1'b0;
            end else if (r_comment) begin
                if (b == bmf_pkg::CH_NEWLINE) begin
                    n_comment = 1'b0;
                end
            end else if (r_string) begin
                if (b == bmf_pkg::CH_BSLASH) begin
                    n_skip = 1'b1;
                end else if (b == bmf_pkg::CH_QUOTE) begin
                    n_string = 1'b0;
                end
            end else if (b == bmf_pkg::CH_SEMI) begin
                n_comment = 1'b1;
            end else if (b == bmf_pkg::CH_QUOTE) begin
                n_string = 1'b1;
            end else if (b == bmf_pkg::CH_BSLASH) begin
                n_skip = 1'b1;
            end else if (open_k != bmf_pkg::KIND_NONE) begin
                o_q_push = 1'b1;
            end else if (close_k != bmf_pkg::KIND_NONE) begin
                o_q_push      = 1'b1;
                o_q_ctrl.code = bmf_pkg::OP_POP;
                o_q_ctrl.kind = close_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_skip    <= 1'b0;
            r_comment <= 1'b0;
            r_string  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_skip    <= n_skip;
            r_comment <= n_comment;
            r_string  <= n_string;
        end
    end

endmodule

@@ rtl/bmf_op_fifo.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder operation queue
// Short FIFO that decouples the front end from the stack engine.
// ----------------------------------------------------------------------------
module bmf_op_fifo #(
    parameter int WIDTH = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_wr_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_rd_data,
    output bmf_pkg::t_q_status o_stat
);

    logic [WIDTH-1:0]                r_mem [bmf_pkg::OPQ_DEPTH];
    logic [bmf_pkg::OPQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [bmf_pkg::OPQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [bmf_pkg::OPQ_CNT_W-1:0]   r_count, n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_stat.full  = (r_count == bmf_pkg::OPQ_CNT_W'(bmf_pkg::OPQ_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/bmf_back.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder stack engine
// Executes push, pop and final-match operations against the opener stack.
// ----------------------------------------------------------------------------
module bmf_back #(
    parameter int STACK_DEPTH   = 1024,
    parameter int POSITION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bmf_pkg::t_op_ctrl        i_q_ctrl,
    input  logic [POSITION_BITS-1:0] i_q_pos,
    input  logic                     i_q_empty,
    output logic                     o_q_pop,
    bmf_out_if.source                o_out_ch
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = bmf_pkg::KIND_W + POSITION_BITS;

    logic [EW-1:0]                r_stack [STACK_DEPTH];
    logic [EW-1:0]                r_rd;
    logic [EW-1:0]                r_byp;
    logic                         r_byp_sel;
    logic [CW-1:0]                r_count, n_count;
    logic [bmf_pkg::STATUS_W-1:0] r_err, n_err;
    logic                         r_out_valid, n_out_valid;
    logic [bmf_pkg::STATUS_W-1:0] r_status, n_status;
    logic [bmf_pkg::MATCH_W-1:0]  r_match, n_match;
    logic                         wr_en;
    logic                         out_free;
    logic [EW-1:0]                top_entry;
    logic [bmf_pkg::KIND_W-1:0]   top_kind;
    logic [POSITION_BITS-1:0]     top_pos;
    logic [bmf_pkg::MATCH_W-1:0]  top_pos_ext;
    logic [CW-1:0]                rd_idx;

    // The top of stack is either the entry just pushed or a registered read.
    assign top_entry = r_byp_sel ? r_byp : r_rd;
    assign top_kind  = top_entry[EW-1 -: bmf_pkg::KIND_W];
    assign top_pos   = top_entry[POSITION_BITS-1:0];

    generate
        if (POSITION_BITS >= bmf_pkg::MATCH_W) begin : g_pos_trunc
            assign top_pos_ext = top_pos[bmf_pkg::MATCH_W-1:0];
        end else begin : g_pos_ext
            assign top_pos_ext = {{(bmf_pkg::MATCH_W - POSITION_BITS){1'b0}}, top_pos};
        end
    endgenerate

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign o_q_pop  = !i_q_empty && ((i_q_ctrl.code != bmf_pkg::OP_LAST) || out_free);

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.status         = r_status;
    assign o_out_ch.match_position = r_match;

    always_comb begin
        n_count     = r_count;
        n_err       = r_err;
        wr_en       = 1'b0;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_status    = r_status;
        n_match     = r_match;
        if (o_q_pop) begin
            case (i_q_ctrl.code)
                bmf_pkg::OP_PUSH: begin
                    if (r_err == bmf_pkg::ERR_NONE) begin
                        if (r_count >= CW'(STACK_DEPTH)) begin
                            n_err = bmf_pkg::ST_OVERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                bmf_pkg::OP_POP: begin
                    if (r_err == bmf_pkg::ERR_NONE) begin
                        if (r_count == '0) begin
                            n_err = bmf_pkg::ST_STRAY;
                        end else begin
                            n_count = r_count - 1'b1;
                            if (top_kind != i_q_ctrl.kind) begin
                                n_err = bmf_pkg::ST_MISMATCH;
                            end
                        end
                    end
                end
                bmf_pkg::OP_LAST: begin
                    n_out_valid = 1'b1;
                    n_match     = '0;
                    if (i_q_ctrl.kind == bmf_pkg::KIND_NONE) begin
                        n_status = bmf_pkg::ST_NOT_CLOSER;
                    end else if (r_err != bmf_pkg::ERR_NONE) begin
                        n_status = r_err;
                    end else if (r_count == '0) begin
                        n_status = bmf_pkg::ST_NONE_OPEN;
                    end else if (top_kind != i_q_ctrl.kind) begin
                        n_status = bmf_pkg::ST_WRONG_KIND;
                    end else begin
                        n_status = bmf_pkg::ST_FOUND;
                        n_match  = top_pos_ext;
                    end
                    n_count = '0;
                    n_err   = bmf_pkg::ERR_NONE;
                end
                default: begin
                end
            endcase
        end
    end

    // Read the entry that will be on top next cycle; a push is bypassed.
    assign rd_idx = n_count - 1'b1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[r_count[AW-1:0]] <= {i_q_ctrl.kind, i_q_pos};
        end
        r_rd  <= r_stack[rd_idx[AW-1:0]];
        r_byp <= {i_q_ctrl.kind, i_q_pos};
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_match  <= n_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= bmf_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
            r_byp_sel   <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_byp_sel   <= wr_en;
        end
    end

endmodule

@@ rtl/bracket_match_finder_core.sv @@
// ----------------------------------------------------------------------------
// Bracket match finder core
// Finds the opener that matches the closing bracket on the last text byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_ch carries one text byte per item; is_closer_byte marks the last
//   item of a text, the closing bracket whose opener is wanted. Bytes are
//   numbered from zero, restarting after every last item.
//   o_out_ch carries one item per text: a status code and, when the status
//   is found, the position of the matching opener.
// Throughput: one input item per cycle while the operation queue has room.
//   Each byte does at most one stack push or pop, and the stack memory
//   serves one write and one registered read per cycle, with the newest
//   entry bypassed. The last byte's operation is registered in the queue,
//   and its result then in the stack engine's output register.
// Stalls: a waiting result is held in the output register. Queued pushes and
//   pops still drain; when the queue fills, i_in_ch.ready drops.
// Reset: control state, counters and the queue are cleared at once. The
//   stack memory is not cleared; only entries written in the current text
//   are read. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "bracket_match_finder_core_defines.svh"

module bracket_match_finder_core #(
    parameter int STACK_DEPTH   = 1024,
    parameter int POSITION_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmf_in_if.sink    i_in_ch,
    bmf_out_if.source o_out_ch
);

    localparam int QW = $bits(bmf_pkg::t_op_ctrl) + POSITION_BITS;

    logic                     q_push;
    bmf_pkg::t_op_ctrl        f_ctrl;
    logic [POSITION_BITS-1:0] f_pos;
    logic                     q_pop;
    bmf_pkg::t_q_status       q_stat;
    logic [QW-1:0]            q_rd_data;
    bmf_pkg::t_op_ctrl        q_ctrl;
    logic [POSITION_BITS-1:0] q_pos;

    bmf_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (i_in_ch),
        .i_q_stat (q_stat),
        .o_q_push (q_push),
        .o_q_ctrl (f_ctrl),
        .o_q_pos  (f_pos)
    );

    bmf_op_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_wr_data ({f_ctrl, f_pos}),
        .i_pop     (q_pop),
        .o_rd_data (q_rd_data),
        .o_stat    (q_stat)
    );

    assign q_ctrl = q_rd_data[QW-1 -: $bits(bmf_pkg::t_op_ctrl)];
    assign q_pos  = q_rd_data[POSITION_BITS-1:0];

    bmf_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_ctrl  (q_ctrl),
        .i_q_pos   (q_pos),
        .i_q_empty (q_stat.empty),
        .o_q_pop   (q_pop),
        .o_out_ch  (o_out_ch)
    );

    `BMF_ASSERT_NEVER(a_q_full_and_empty, i_clk, i_rst_n, q_stat.full && q_stat.empty, "queue is both full and empty")
    `BMF_ASSERT(a_q_no_overfill, i_clk, i_rst_n, q_push |-> !q_stat.full, "item queued while the queue is full")
    `BMF_ASSERT(a_last_gives_result, i_clk, i_rst_n, (q_pop && q_ctrl.code == bmf_pkg::OP_LAST) |=> o_out_ch.valid, "last item taken without a result")

endmodule

@@ dv/bmf_match_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket match finder checker
// Watches both channels, tracks the text scan on its own copy of the bracket
// stack, and compares every result item with the oldest predicted result.
// ----------------------------------------------------------------------------
module bmf_match_checker #(
    parameter int STACK_DEPTH   = 1024,
    parameter int POSITION_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmf_in_if          i_in_mon,
    bmf_out_if         i_out_mon,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_result_count,
    output logic [7:0] o_status_seen
);

    localparam int BW = bmf_pkg::BYTE_W;
    localparam int KW = bmf_pkg::KIND_W;
    localparam int SW = bmf_pkg::STATUS_W;
    localparam int MW = bmf_pkg::MATCH_W;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [MW-1:0] position;
    } t_match_result;

    t_match_result            expected_matches[$];
    logic [POSITION_BITS-1:0] text_pos;
    logic [POSITION_BITS-1:0] open_pos_mem [STACK_DEPTH];
    logic [KW-1:0]            open_kind_mem [STACK_DEPTH];
    int unsigned              open_count;
    bit                       comment_mode;
    bit                       string_mode;
    bit                       skip_one;
    logic [SW-1:0]            scan_status;

    function automatic void classify(input logic [BW-1:0] b, output bit opens,
                                     output bit closes, output logic [KW-1:0] kind);
        opens  = 1'b0;
        closes = 1'b0;
        kind   = bmf_pkg::KIND_NONE;
        case (b)
            bmf_pkg::CH_LPAREN: begin opens  = 1'b1; kind = bmf_pkg::KIND_PAREN; end
            bmf_pkg::CH_LBRACK: begin opens  = 1'b1; kind = bmf_pkg::KIND_BRACK; end
            bmf_pkg::CH_LBRACE: begin opens  = 1'b1; kind = bmf_pkg::KIND_BRACE; end
            bmf_pkg::CH_RPAREN: begin closes = 1'b1; kind = bmf_pkg::KIND_PAREN; end
            bmf_pkg::CH_RBRACK: begin closes = 1'b1; kind = bmf_pkg::KIND_BRACK; end
            bmf_pkg::CH_RBRACE: begin closes = 1'b1; kind = bmf_pkg::KIND_BRACE; end
            default: ;
        endcase
    endfunction

    task automatic clear_scan();
        text_pos     = '0;
        open_count   = 0;
        comment_mode = 1'b0;
        string_mode  = 1'b0;
        skip_one     = 1'b0;
        scan_status  = bmf_pkg::ERR_NONE;
    endtask

    // One byte before the last one of a text. After an error only the
    // position keeps counting.
    task automatic scan_byte(input logic [BW-1:0] b, input logic [POSITION_BITS-1:0] pos);
        bit            opens;
        bit            closes;
        logic [KW-1:0] kind;
        if (scan_status != bmf_pkg::ERR_NONE) return;
        if (skip_one) begin
            skip_one = 1'b0;
            return;
        end
        if (comment_mode) begin
            if (b == bmf_pkg::CH_NEWLINE) comment_mode = 1'b0;
            return;
        end
        if (string_mode) begin
            if (b == bmf_pkg::CH_BSLASH) skip_one = 1'b1;
            else if (b == bmf_pkg::CH_QUOTE) string_mode = 1'b0;
            return;
        end
        case (b)
            bmf_pkg::CH_SEMI:   comment_mode = 1'b1;
            bmf_pkg::CH_QUOTE:  string_mode = 1'b1;
            bmf_pkg::CH_BSLASH: skip_one = 1'b1;
            default: begin
                classify(b, opens, closes, kind);
                if (opens) begin
                    if (open_count >= STACK_DEPTH) begin
                        scan_status = bmf_pkg::ST_OVERFLOW;
                    end else begin
                        open_pos_mem[open_count]  = pos;
                        open_kind_mem[open_count] = kind;
                        open_count++;
                    end
                end else if (closes) begin
                    if (open_count == 0) begin
                        scan_status = bmf_pkg::ST_STRAY;
                    end else begin
                        open_count--;
                        if (open_kind_mem[open_count] != kind) begin
                            scan_status = bmf_pkg::ST_MISMATCH;
                        end
                    end
                end
            end
        endcase
    endtask

    // The last byte decides the result; comment, string and skip state are
    // ignored for it.
    task automatic close_text(input logic [BW-1:0] b);
        bit            opens;
        bit            closes;
        logic [KW-1:0] want;
        t_match_result res;
        classify(b, opens, closes, want);
        res.status   = bmf_pkg::ST_FOUND;
        res.position = '0;
        if (!closes) res.status = bmf_pkg::ST_NOT_CLOSER;
        else if (scan_status != bmf_pkg::ERR_NONE) res.status = scan_status;
        else if (open_count == 0) res.status = bmf_pkg::ST_NONE_OPEN;
        else if (open_kind_mem[open_count-1] != want) res.status = bmf_pkg::ST_WRONG_KIND;
        else res.position = MW'(open_pos_mem[open_count-1]);
        expected_matches.push_back(res);
        clear_scan();
    endtask

    always @(posedge i_clk) begin : monitor
        t_match_result exp_res;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_scan();
            expected_matches.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
            o_status_seen  <= '0;
            o_pending      <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.is_closer_byte) begin
                    close_text(i_in_mon.text_byte);
                end else begin
                    scan_byte(i_in_mon.text_byte, text_pos);
                    text_pos = text_pos + 1'b1;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_result_count <= o_result_count + 1;
                o_status_seen[i_out_mon.status] <= 1'b1;
                if (expected_matches.size() == 0) begin
                    $error("result item with none expected: status %0d, match_position %0d",
                           i_out_mon.status, i_out_mon.match_position);
                    errs++;
                end else begin
                    exp_res = expected_matches.pop_front();
                    if (i_out_mon.status !== exp_res.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, i_out_mon.status);
                        errs++;
                    end
                    if (i_out_mon.match_position !== exp_res.position) begin
                        $error("match_position mismatch: expected %0d, actual %0d",
                               exp_res.position, i_out_mon.match_position);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= expected_matches.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bracket match finder testbench
// Streams directed and random texts through the core, with random idling on
// both channels and one long output stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STACK_DEPTH    = 1024;
    localparam int POSITION_BITS  = 20;
    localparam int BW             = bmf_pkg::BYTE_W;
    localparam int KW             = bmf_pkg::KIND_W;
    localparam int RANDOM_BYTES   = 700;
    localparam int MIN_TEXTS      = 20;
    localparam int DEEP_TEXT      = 64;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk;
    logic i_rst_n;

    bmf_in_if  in_ch ();
    bmf_out_if out_ch ();

    int         fail_count;
    int         pending_count;
    int         result_count;
    logic [7:0] status_seen;

    int            bytes_sent = 0;
    int            texts_sent = 0;
    int            long_hold_reqs = 0;
    int            long_holds_done = 0;
    int            idle_cycles = 0;
    int            ready_left = 0;
    bit            sender_burst = 1'b0;
    logic [BW-1:0] text_buf[$];

    bracket_match_finder_core #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    bmf_match_checker #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count),
        .o_status_seen  (status_seen)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Result receiver: runs of ready and stalls of random length, plus the
    // long hold-off requested by the stimulus.
    always @(posedge i_clk) begin : receiver
        int r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            ready_left   <= 0;
        end else if (long_hold_reqs != long_holds_done) begin
            long_holds_done <= long_holds_done + 1;
            out_ch.ready    <= 1'b0;
            ready_left      <= LONG_HOLD;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                out_ch.ready <= 1'b1;
                ready_left   <= $urandom_range(0, 7);
            end else if (r < 70) begin
                out_ch.ready <= 1'b1;
                ready_left   <= $urandom_range(30, 120);
            end else if (r < 92) begin
                out_ch.ready <= 1'b0;
                ready_left   <= $urandom_range(0, 2);
            end else if (r < 98) begin
                out_ch.ready <= 1'b0;
                ready_left   <= $urandom_range(3, 12);
            end else begin
                out_ch.ready <= 1'b0;
                ready_left   <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [BW-1:0] opener_byte(input logic [KW-1:0] k);
        case (k)
            bmf_pkg::KIND_PAREN: return bmf_pkg::CH_LPAREN;
            bmf_pkg::KIND_BRACK: return bmf_pkg::CH_LBRACK;
            default:             return bmf_pkg::CH_LBRACE;
        endcase
    endfunction

    function automatic logic [BW-1:0] closer_byte(input logic [KW-1:0] k);
        case (k)
            bmf_pkg::KIND_PAREN: return bmf_pkg::CH_RPAREN;
            bmf_pkg::KIND_BRACK: return bmf_pkg::CH_RBRACK;
            default:             return bmf_pkg::CH_RBRACE;
        endcase
    endfunction

    function automatic logic [KW-1:0] random_kind();
        return KW'($urandom_range(0, 2));
    endfunction

    function automatic logic [BW-1:0] any_bracket();
        if ($urandom_range(0, 1)) return opener_byte(random_kind());
        return closer_byte(random_kind());
    endfunction

    // A byte with no meaning to the scanner.
    function automatic logic [BW-1:0] plain_byte();
        logic [BW-1:0] b;
        b = BW'($urandom_range(0, 255));
        case (b)
            bmf_pkg::CH_LPAREN, bmf_pkg::CH_LBRACK, bmf_pkg::CH_LBRACE,
            bmf_pkg::CH_RPAREN, bmf_pkg::CH_RBRACK, bmf_pkg::CH_RBRACE,
            bmf_pkg::CH_SEMI, bmf_pkg::CH_QUOTE, bmf_pkg::CH_BSLASH,
            bmf_pkg::CH_NEWLINE: b = 8'h61 + b[3:0];
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [BW-1:0] comment_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return any_bracket();
        if (r < 40) return bmf_pkg::CH_BSLASH;
        if (r < 50) return bmf_pkg::CH_QUOTE;
        return plain_byte();
    endfunction

    task automatic add_string_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            text_buf.push_back(bmf_pkg::CH_BSLASH);
            text_buf.push_back(BW'($urandom_range(0, 255)));
        end else if (r < 50) begin
            text_buf.push_back(any_bracket());
        end else if (r < 60) begin
            text_buf.push_back(bmf_pkg::CH_SEMI);
        end else if (r < 65) begin
            text_buf.push_back(bmf_pkg::CH_NEWLINE);
        end else begin
            text_buf.push_back(plain_byte());
        end
    endtask

    // Properly nested brackets with comments, strings and escapes between
    // them; the last byte usually closes the innermost opener.
    task automatic build_balanced_text(output logic [BW-1:0] last_byte);
        logic [KW-1:0] open_kinds[$];
        logic [KW-1:0] k;
        int            steps;
        int            r;
        text_buf.delete();
        steps = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 30 && open_kinds.size() < 20) begin
                k = random_kind();
                open_kinds.push_back(k);
                text_buf.push_back(opener_byte(k));
            end else if (r < 50 && open_kinds.size() > 0) begin
                text_buf.push_back(closer_byte(open_kinds.pop_back()));
            end else if (r < 58) begin
                text_buf.push_back(bmf_pkg::CH_SEMI);
                repeat ($urandom_range(0, 6)) text_buf.push_back(comment_byte());
                text_buf.push_back(bmf_pkg::CH_NEWLINE);
            end else if (r < 66) begin
                text_buf.push_back(bmf_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6)) add_string_byte();
                text_buf.push_back(bmf_pkg::CH_QUOTE);
            end else if (r < 71) begin
                text_buf.push_back(bmf_pkg::CH_BSLASH);
                text_buf.push_back(BW'($urandom_range(0, 255)));
            end else begin
                text_buf.push_back(plain_byte());
            end
        end
        if (open_kinds.size() == 0) begin
            k = random_kind();
            open_kinds.push_back(k);
            text_buf.push_back(opener_byte(k));
        end
        k = open_kinds[$];
        if ($urandom_range(0, 9) == 0) k = KW'((int'(k) + 1 + $urandom_range(0, 1)) % 3);
        last_byte = closer_byte(k);
    endtask

    task automatic build_noise_text(output logic [BW-1:0] last_byte);
        int r;
        text_buf.delete();
        repeat ($urandom_range(0, 20)) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                text_buf.push_back(any_bracket());
            end else if (r < 55) begin
                case ($urandom_range(0, 3))
                    0:       text_buf.push_back(bmf_pkg::CH_SEMI);
                    1:       text_buf.push_back(bmf_pkg::CH_QUOTE);
                    2:       text_buf.push_back(bmf_pkg::CH_BSLASH);
                    default: text_buf.push_back(bmf_pkg::CH_NEWLINE);
                endcase
            end else begin
                text_buf.push_back(BW'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 99) < 60) last_byte = closer_byte(random_kind());
        else last_byte = BW'($urandom_range(0, 255));
    endtask

    task automatic build_deep_text(input int depth, output logic [BW-1:0] last_byte);
        logic [KW-1:0] k;
        text_buf.delete();
        k = bmf_pkg::KIND_PAREN;
        repeat (depth) begin
            k = random_kind();
            text_buf.push_back(opener_byte(k));
        end
        last_byte = closer_byte(k);
    endtask

    function automatic int pick_gap();
        int r;
        if (sender_burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_byte(input logic [BW-1:0] b, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.text_byte      <= b;
        in_ch.is_closer_byte <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [BW-1:0] last_byte);
        foreach (text_buf[i]) send_byte(text_buf[i], 1'b0);
        send_byte(last_byte, 1'b1);
        texts_sent++;
    endtask

    task automatic send_literal(input string body, input logic [BW-1:0] last_byte);
        text_buf.delete();
        for (int i = 0; i < body.len(); i++) text_buf.push_back(body[i]);
        send_text(last_byte);
    endtask

    initial begin : stimulus
        logic [BW-1:0] last_byte;
        int            random_texts;
        int            start_bytes;
        random_texts         = 0;
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.text_byte      <= '0;
        in_ch.is_closer_byte <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each status other than overflow, and the scanner's corner cases.
        send_literal("", bmf_pkg::CH_RPAREN);
        send_literal("(", bmf_pkg::CH_RPAREN);
        send_literal("x[", bmf_pkg::CH_RBRACK);
        send_literal("{", bmf_pkg::CH_RBRACE);
        send_literal("(", bmf_pkg::CH_RBRACE);
        send_literal("(", 8'h00);
        send_literal("", 8'hFF);
        send_literal(")", bmf_pkg::CH_RPAREN);
        send_literal("(](", bmf_pkg::CH_RPAREN);
        send_literal("(]", 8'h41);
        send_literal("(;)\n", bmf_pkg::CH_RPAREN);
        send_literal("(\"\\\")\"", bmf_pkg::CH_RPAREN);
        send_literal("(\\)", bmf_pkg::CH_RPAREN);
        send_literal("(;\\\n[", bmf_pkg::CH_RBRACK);
        send_literal("(\\", bmf_pkg::CH_RPAREN);
        send_literal("[\"", bmf_pkg::CH_RBRACK);
        send_literal("{;", bmf_pkg::CH_RBRACE);

        // A deep nest of openers sent back to back.
        sender_burst = 1'b1;
        build_deep_text(DEEP_TEXT, last_byte);
        send_text(last_byte);
        sender_burst = 1'b0;

        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES || random_texts < MIN_TEXTS) begin
            if (random_texts == 15) begin
                // Results pile up behind a long receiver hold-off.
                long_hold_reqs++;
                sender_burst = 1'b1;
                repeat (12) begin
                    if ($urandom_range(0, 1)) build_balanced_text(last_byte);
                    else build_noise_text(last_byte);
                    send_text(last_byte);
                end
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) build_balanced_text(last_byte);
            else build_noise_text(last_byte);
            send_text(last_byte);
            random_texts++;
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d text bytes in %0d texts, including a nest %0d openers deep.",
                 bytes_sent, texts_sent, DEEP_TEXT);
        $display("Checked %0d results; status codes seen (7..0): %b", result_count, status_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_stream_if.sv
rtl/bmf_front.sv
rtl/bmf_op_fifo.sv
rtl/bmf_back.sv
rtl/bracket_match_finder_core.sv
dv/bmf_match_checker.sv
dv/tb_top.sv
